// ----- design/fetc_pkg.sv -----
`default_nettype none
package fetc_pkg;

   // Port widths of the sample point and of the iteration count
   localparam int COORD_WIDTH = 32;
   localparam int ITER_WIDTH  = 16;

   // Internal formats: z and c in Q4.28, squares and products in Q8.56
   localparam int Z_W    = 32;
   localparam int Z_FRAC = 28;
   localparam int PROD_W = 2 * Z_W;
   localparam int SUM_W  = Z_W + 6;
   localparam logic [PROD_W-1:0] ESCAPE_LIMIT = PROD_W'(5) << 56;

   // Colour side
   localparam int COL_W = 24;
   localparam int F_W   = 17;
   localparam logic [F_W-1:0] F_ONE = F_W'(65536);
   localparam int ROOT_W   = PROD_W / 2;
   localparam int MAG_SHIFT = 12;
   // Reciprocal of ten, exact for the 20-bit root>>12 operand
   localparam logic [Z_W-1:0] MAG_RECIP = Z_W'(838861);
   localparam int MAG_RECIP_SHIFT = 23;

   // Serial divider sizes: count mode divides i<<16 by the limit
   localparam int DIV_W = ITER_WIDTH + 16;
   localparam int DVS_W = ITER_WIDTH;

   // Register port
   localparam int CSR_DATA_W  = (COORD_WIDTH > 32) ? 64 : 32;
   localparam int CSR_SHIFT   = (COORD_WIDTH > 32) ? 3 : 2;
   localparam int CSR_ADDR_W  = CSR_SHIFT + 3;

   typedef enum logic [2:0] {
      REG_MODE          = 3'd0,
      REG_MAX_ITER      = 3'd1,
      REG_PARAM_RE      = 3'd2,
      REG_PARAM_IM      = 3'd3,
      REG_INNER_ENABLE  = 3'd4,
      REG_INNER_COLOR   = 3'd5,
      REG_GRADIENT_NEAR = 3'd6,
      REG_GRADIENT_FAR  = 3'd7
   } csr_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT_XX,
      ST_INIT_YY,
      ST_XY,
      ST_XX,
      ST_YY,
      ST_CHK,
      ST_PICK,
      ST_SQRT,
      ST_MAG,
      ST_DIV,
      ST_T2,
      ST_T3,
      ST_CUBE,
      ST_BLEND
   } state_type;

   // Align a Q4.(COORD_WIDTH-4) value to Q4.28, flooring when wider
   function automatic logic signed [Z_W-1:0] to_q428(input logic [COORD_WIDTH-1:0] v);
      logic [COORD_WIDTH+Z_W-1:0] w;
      w = {v, {Z_W{1'b0}}};
      return $signed(w[COORD_WIDTH+Z_W-1 -: Z_W]);
   endfunction

   // Clamp a widened sum to the Q4.28 range
   function automatic logic signed [Z_W-1:0] sat_z(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'($signed({1'b0, {(Z_W-1){1'b1}}}));
      lo = SUM_W'($signed({1'b1, {(Z_W-1){1'b0}}}));
      if (v > hi) begin
         return hi[Z_W-1:0];
      end else if (v < lo) begin
         return lo[Z_W-1:0];
      end
      return v[Z_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ----- design/fetc_div.sv -----
`default_nettype none
module fetc_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [fetc_pkg::DIV_W-1:0]     dividend,
   input  wire logic [fetc_pkg::DVS_W-1:0]     divisor,
   output logic                                done,
   output logic [fetc_pkg::DIV_W-1:0]          quotient
);

   localparam int CNT_W = $clog2(fetc_pkg::DIV_W);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [fetc_pkg::DIV_W-1:0]   quo_ff, quo_in;
   logic [fetc_pkg::DVS_W-1:0]   rem_ff, rem_in;
   logic [fetc_pkg::DVS_W-1:0]   dvs_ff, dvs_in;
   logic [fetc_pkg::DVS_W:0]     trial;

   // One quotient bit per cycle, restoring
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, quo_ff[fetc_pkg::DIV_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(fetc_pkg::DIV_W - 1);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = fetc_pkg::DVS_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[fetc_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[fetc_pkg::DVS_W-1:0];
            quo_in = {quo_ff[fetc_pkg::DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ----- design/fetc_isqrt.sv -----
`default_nettype none
module fetc_isqrt (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [fetc_pkg::PROD_W-1:0]     radicand,
   output logic                                 done,
   output logic [fetc_pkg::ROOT_W-1:0]          root
);

   localparam int CNT_W = $clog2(fetc_pkg::ROOT_W);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [fetc_pkg::PROD_W-1:0]   v_ff, v_in;
   logic [fetc_pkg::PROD_W-1:0]   res_ff, res_in;
   logic [fetc_pkg::PROD_W-1:0]   bit_ff, bit_in;
   logic [fetc_pkg::PROD_W-1:0]   trial;

   // Settle one root bit per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      v_in    = v_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      trial   = res_ff + bit_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(fetc_pkg::ROOT_W - 1);
         v_in    = radicand;
         res_in  = '0;
         bit_in  = fetc_pkg::PROD_W'(1) << (fetc_pkg::PROD_W - 2);
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_in   = v_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      v_ff   <= v_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[fetc_pkg::ROOT_W-1:0];

endmodule
`default_nettype wire

// ----- design/fractal_escape_time_colorizer.sv -----
`default_nettype none
// Channel   Direction  Ports
// req       in         req_valid, req_ready, req_point_re, req_point_im
// rsp       out        rsp_valid, rsp_ready, rsp_pixel_rgb, rsp_iter_count, rsp_is_inner
// csr       in/out     csr_psel, csr_penable, csr_pwrite, csr_paddr, csr_pwdata,
//                      csr_prdata, csr_pready
//
// One shared 32x32 multiplier serves the whole item: initial squares in
// INIT_XX and INIT_YY, each complex step in XY, XX, YY and CHK (i+1 steps
// on escape, else the limit), and PICK to choose the colour path. Count
// colouring adds the serial divide, T2, T3 and CUBE; magnitude colouring the serial
// square root and one scaling product in MAG; the inner colour none. BLEND loads the output register.
// req_ready is high only while the sequencer is idle; a finished item waits
// in the output register and the next item may be taken meanwhile.
// Reset is synchronous, active high, and restores the register defaults.
module fractal_escape_time_colorizer (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [fetc_pkg::COORD_WIDTH-1:0]    req_point_re,
   input  wire logic [fetc_pkg::COORD_WIDTH-1:0]    req_point_im,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [fetc_pkg::COL_W-1:0]               rsp_pixel_rgb,
   output logic [fetc_pkg::ITER_WIDTH-1:0]          rsp_iter_count,
   output logic                                     rsp_is_inner,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [fetc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [fetc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [fetc_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                     csr_pready
);

   localparam int IW = fetc_pkg::ITER_WIDTH;
   localparam int CW = fetc_pkg::COORD_WIDTH;
   localparam int DW = fetc_pkg::CSR_DATA_W;
   localparam int ZW = fetc_pkg::Z_W;
   localparam int PW = fetc_pkg::PROD_W;
   localparam int FW = fetc_pkg::F_W;

   // Configuration registers
   logic [1:0]                   mode_ff;
   logic [IW-1:0]                max_iter_ff;
   logic [CW-1:0]                param_re_ff;
   logic [CW-1:0]                param_im_ff;
   logic                         inner_en_ff;
   logic [fetc_pkg::COL_W-1:0]   inner_color_ff;
   logic [fetc_pkg::COL_W-1:0]   grad_near_ff;
   logic [fetc_pkg::COL_W-1:0]   grad_far_ff;
   fetc_pkg::csr_reg_type        csr_idx;
   logic                         csr_wr;

   // Sequencer and datapath
   fetc_pkg::state_type          state_ff, state_in;
   logic signed [ZW-1:0]         zr_ff, zr_in, zi_ff, zi_in;
   logic signed [ZW-1:0]         cr_ff, cr_in, ci_ff, ci_in;
   logic signed [PW-1:0]         xx_ff, xx_in, yy_ff, yy_in, xy_ff, xy_in;
   logic [PW-1:0]                mag_ff, mag_in;
   logic [IW-1:0]                iter_ff, iter_in;
   logic [IW-1:0]                limit_ff, limit_in;
   logic                         inner_ff, inner_in;
   logic [FW-1:0]                t_ff, t_in, t2_ff, t2_in, t3_ff, t3_in, f_ff, f_in;

   // Output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [fetc_pkg::COL_W-1:0]   rgb_ff, rgb_in;
   logic [IW-1:0]                cnt_ff, cnt_in;
   logic                         is_inner_ff, is_inner_in;

   // Shared multiplier
   logic signed [ZW-1:0]         mul_a, mul_b;
   logic signed [PW-1:0]         mul_p;

   // Helpers
   logic signed [PW-1:0]         diff_re;
   logic signed [fetc_pkg::SUM_W-1:0] sum_re, sum_im;
   logic [PW-1:0]                mag_now;
   logic                         escape;
   logic [IW:0]                  iter_next;
   logic [FW+1:0]                cube;
   logic [fetc_pkg::COL_W-1:0]   blend_rgb;
   logic [IW-1:0]                lim_new;
   logic [FW-1:0]                mag_q;

   // Serial units
   logic                         sqrt_start, sqrt_done;
   logic [fetc_pkg::ROOT_W-1:0]  sqrt_root;
   logic                         div_start, div_done;
   logic [fetc_pkg::DIV_W-1:0]   div_dvd, div_quo;
   logic [fetc_pkg::DVS_W-1:0]   div_dvs;

   fetc_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (mag_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   fetc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Register port: write on the access cycle, read back combinationally
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = fetc_pkg::csr_reg_type'(csr_paddr[fetc_pkg::CSR_ADDR_W-1:fetc_pkg::CSR_SHIFT]);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= '0;
         max_iter_ff    <= IW'(256);
         param_re_ff    <= '0;
         param_im_ff    <= '0;
         inner_en_ff    <= 1'b1;
         inner_color_ff <= '0;
         grad_near_ff   <= '1;
         grad_far_ff    <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            fetc_pkg::REG_MODE:          mode_ff        <= csr_pwdata[1:0];
            fetc_pkg::REG_MAX_ITER:      max_iter_ff    <= csr_pwdata[IW-1:0];
            fetc_pkg::REG_PARAM_RE:      param_re_ff    <= csr_pwdata[CW-1:0];
            fetc_pkg::REG_PARAM_IM:      param_im_ff    <= csr_pwdata[CW-1:0];
            fetc_pkg::REG_INNER_ENABLE:  inner_en_ff    <= csr_pwdata[0];
            fetc_pkg::REG_INNER_COLOR:   inner_color_ff <= csr_pwdata[fetc_pkg::COL_W-1:0];
            fetc_pkg::REG_GRADIENT_NEAR: grad_near_ff   <= csr_pwdata[fetc_pkg::COL_W-1:0];
            fetc_pkg::REG_GRADIENT_FAR:  grad_far_ff    <= csr_pwdata[fetc_pkg::COL_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         fetc_pkg::REG_MODE:          csr_prdata = DW'(mode_ff);
         fetc_pkg::REG_MAX_ITER:      csr_prdata = DW'(max_iter_ff);
         fetc_pkg::REG_PARAM_RE:      csr_prdata = DW'(param_re_ff);
         fetc_pkg::REG_PARAM_IM:      csr_prdata = DW'(param_im_ff);
         fetc_pkg::REG_INNER_ENABLE:  csr_prdata = DW'(inner_en_ff);
         fetc_pkg::REG_INNER_COLOR:   csr_prdata = DW'(inner_color_ff);
         fetc_pkg::REG_GRADIENT_NEAR: csr_prdata = DW'(grad_near_ff);
         fetc_pkg::REG_GRADIENT_FAR:  csr_prdata = DW'(grad_far_ff);
      endcase
   end

   // Complex step arithmetic off registered squares and product
   assign mul_p     = mul_a * mul_b;
   assign diff_re   = xx_ff - yy_ff;
   assign sum_re    = fetc_pkg::SUM_W'($signed(diff_re[PW-1:fetc_pkg::Z_FRAC]))
                      + fetc_pkg::SUM_W'(cr_ff);
   assign sum_im    = fetc_pkg::SUM_W'($signed(xy_ff[PW-1:fetc_pkg::Z_FRAC-1]))
                      + fetc_pkg::SUM_W'(ci_ff);
   assign mag_now   = $unsigned(xx_ff) + $unsigned(yy_ff);
   assign escape    = mag_now > fetc_pkg::ESCAPE_LIMIT;
   assign iter_next = {1'b0, iter_ff} + 1'b1;
   assign cube      = (FW+2)'(t_ff) * (FW+2)'(3) + (FW+2)'(t3_ff) - (FW+2)'(t2_ff) * (FW+2)'(3);
   assign lim_new   = (max_iter_ff == '0) ? IW'(1) : max_iter_ff;
   // Root over 40960 as (root>>12) times the reciprocal of ten
   assign mag_q     = mul_p[fetc_pkg::MAG_RECIP_SHIFT+FW-1:fetc_pkg::MAG_RECIP_SHIFT];

   // Blend each channel between far and near by f
   always_comb begin
      logic signed [8:0]  d;
      logic signed [26:0] p;
      for (int k = 0; k < 3; k++) begin
         d = $signed({1'b0, grad_near_ff[8*k +: 8]}) - $signed({1'b0, grad_far_ff[8*k +: 8]});
         p = 27'(d) * 27'($signed({1'b0, f_ff}));
         blend_rgb[8*k +: 8] = grad_far_ff[8*k +: 8] + p[23:16];
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      xx_in        = xx_ff;
      yy_in        = yy_ff;
      xy_in        = xy_ff;
      mag_in       = mag_ff;
      iter_in      = iter_ff;
      limit_in     = limit_ff;
      inner_in     = inner_ff;
      t_in         = t_ff;
      t2_in        = t2_ff;
      t3_in        = t3_ff;
      f_in         = f_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rgb_in       = rgb_ff;
      cnt_in       = cnt_ff;
      is_inner_in  = is_inner_ff;
      mul_a        = zr_ff;
      mul_b        = zr_ff;
      sqrt_start   = 1'b0;
      div_start    = 1'b0;
      div_dvd      = fetc_pkg::DIV_W'({iter_ff, 16'b0});
      div_dvs      = limit_ff;
      req_ready    = 1'b0;
      unique case (state_ff)
         fetc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (mode_ff[0]) begin
                  zr_in = fetc_pkg::to_q428(req_point_re);
                  zi_in = fetc_pkg::to_q428(req_point_im);
                  cr_in = fetc_pkg::to_q428(param_re_ff);
                  ci_in = fetc_pkg::to_q428(param_im_ff);
               end else begin
                  zr_in = fetc_pkg::to_q428(param_re_ff);
                  zi_in = fetc_pkg::to_q428(param_im_ff);
                  cr_in = fetc_pkg::to_q428(req_point_re);
                  ci_in = fetc_pkg::to_q428(req_point_im);
               end
               iter_in  = '0;
               limit_in = lim_new;
               state_in = fetc_pkg::ST_INIT_XX;
            end
         end
         fetc_pkg::ST_INIT_XX: begin
            xx_in    = mul_p;
            state_in = fetc_pkg::ST_INIT_YY;
         end
         fetc_pkg::ST_INIT_YY: begin
            mul_a    = zi_ff;
            mul_b    = zi_ff;
            yy_in    = mul_p;
            state_in = fetc_pkg::ST_XY;
         end
         fetc_pkg::ST_XY: begin
            // product of the old z, new real part from the old squares
            mul_b    = zi_ff;
            xy_in    = mul_p;
            zr_in    = fetc_pkg::sat_z(sum_re);
            state_in = fetc_pkg::ST_XX;
         end
         fetc_pkg::ST_XX: begin
            xx_in    = mul_p;
            zi_in    = fetc_pkg::sat_z(sum_im);
            state_in = fetc_pkg::ST_YY;
         end
         fetc_pkg::ST_YY: begin
            mul_a    = zi_ff;
            mul_b    = zi_ff;
            yy_in    = mul_p;
            state_in = fetc_pkg::ST_CHK;
         end
         fetc_pkg::ST_CHK: begin
            mag_in = mag_now;
            if (escape) begin
               state_in = fetc_pkg::ST_PICK;
            end else begin
               iter_in = iter_next[IW-1:0];
               if (iter_next == {1'b0, limit_ff}) begin
                  state_in = fetc_pkg::ST_PICK;
               end else begin
                  state_in = fetc_pkg::ST_XY;
               end
            end
         end
         fetc_pkg::ST_PICK: begin
            inner_in = (iter_next >= {1'b0, limit_ff}) && inner_en_ff;
            if ((iter_next >= {1'b0, limit_ff}) && inner_en_ff) begin
               state_in = fetc_pkg::ST_BLEND;
            end else if (mode_ff[1]) begin
               sqrt_start = 1'b1;
               state_in   = fetc_pkg::ST_SQRT;
            end else begin
               div_start = 1'b1;
               state_in  = fetc_pkg::ST_DIV;
            end
         end
         fetc_pkg::ST_SQRT: begin
            if (sqrt_done) begin
               state_in = fetc_pkg::ST_MAG;
            end
         end
         fetc_pkg::ST_MAG: begin
            mul_a    = ZW'($signed({1'b0, sqrt_root[fetc_pkg::ROOT_W-1:fetc_pkg::MAG_SHIFT]}));
            mul_b    = fetc_pkg::MAG_RECIP;
            f_in     = (mag_q > fetc_pkg::F_ONE) ? fetc_pkg::F_ONE : mag_q;
            state_in = fetc_pkg::ST_BLEND;
         end
         fetc_pkg::ST_DIV: begin
            if (div_done) begin
               t_in     = div_quo[FW-1:0];
               state_in = fetc_pkg::ST_T2;
            end
         end
         fetc_pkg::ST_T2: begin
            mul_a    = ZW'($signed({1'b0, t_ff}));
            mul_b    = ZW'($signed({1'b0, t_ff}));
            t2_in    = mul_p[FW+15:16];
            state_in = fetc_pkg::ST_T3;
         end
         fetc_pkg::ST_T3: begin
            mul_a    = ZW'($signed({1'b0, t2_ff}));
            mul_b    = ZW'($signed({1'b0, t_ff}));
            t3_in    = mul_p[FW+15:16];
            state_in = fetc_pkg::ST_CUBE;
         end
         fetc_pkg::ST_CUBE: begin
            f_in     = (cube > (FW+2)'(fetc_pkg::F_ONE)) ? fetc_pkg::F_ONE : cube[FW-1:0];
            state_in = fetc_pkg::ST_BLEND;
         end
         fetc_pkg::ST_BLEND: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rgb_in       = inner_ff ? inner_color_ff : blend_rgb;
               cnt_in       = iter_ff;
               is_inner_in  = inner_ff;
               state_in     = fetc_pkg::ST_IDLE;
            end
         end
         default: state_in = fetc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fetc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      zr_ff       <= zr_in;
      zi_ff       <= zi_in;
      cr_ff       <= cr_in;
      ci_ff       <= ci_in;
      xx_ff       <= xx_in;
      yy_ff       <= yy_in;
      xy_ff       <= xy_in;
      mag_ff      <= mag_in;
      iter_ff     <= iter_in;
      limit_ff    <= limit_in;
      inner_ff    <= inner_in;
      t_ff        <= t_in;
      t2_ff       <= t2_in;
      t3_ff       <= t3_in;
      f_ff        <= f_in;
      rgb_ff      <= rgb_in;
      cnt_ff      <= cnt_in;
      is_inner_ff <= is_inner_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_rgb  = rgb_ff;
   assign rsp_iter_count = cnt_ff;
   assign rsp_is_inner   = is_inner_ff;

endmodule
`default_nettype wire
